[design/mrpt_pkg.sv]
// Shared types, constants and helper functions for the Miller-Rabin primality tester.
// Used by mrpt_modmul, mrpt_seq and miller_rabin_primality_test; depends on nothing.
`timescale 1ns / 1ps

package mrpt_pkg;

   localparam int MAX_ROUNDS      = 64;
   localparam int ROUNDS_WIDTH    = 7;
   localparam int RAND_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROUNDS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED   = 2'd1;

   localparam logic [ROUNDS_WIDTH-1:0] ROUNDS_RESET = 7'd8;
   localparam logic [RAND_WIDTH-1:0]   SEED_RESET   = 32'd1;
   localparam logic [RAND_WIDTH-1:0]   LFSR_TAPS    = 32'h8020_0003;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_SPLIT,
      SEQ_ROUND,
      SEQ_WITNESS,
      SEQ_POW,
      SEQ_POW_ACC,
      SEQ_POW_SQR,
      SEQ_CHECK,
      SEQ_SQ,
      SEQ_SQ_WAIT,
      SEQ_NEXT,
      SEQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic                    valid;
      logic                    prime;
      logic [ROUNDS_WIDTH-1:0] rounds;
   } verdict_type;

   function automatic logic [RAND_WIDTH-1:0] lfsr_next(input logic [RAND_WIDTH-1:0] s);
      logic [RAND_WIDTH-1:0] shifted;
      shifted = s >> 1;
      return s[0] ? (shifted ^ LFSR_TAPS) : shifted;
   endfunction

endpackage

[design/miller_rabin_primality_test.sv]
// Top level of the Miller-Rabin primality tester: configuration registers, LFSR,
// result register and handshakes. Depends on mrpt_pkg, mrpt_seq and mrpt_modmul.
`timescale 1ns / 1ps
//
// A candidate moves in on the req_ channel and one verdict moves out on the rsp_
// channel per candidate. A transfer happens at a clock edge where valid is high and
// stall is low. The csr_ port writes the round count (index 0) and the LFSR seed
// (index 1); writes to other indexes are ignored. Write only while the block is idle.
// Candidates below 4, even candidates and a round count of zero go straight to the
// finish state. Otherwise n-1 is split first, and every modular product runs on the
// single shared shift-and-add multiplier, with a start and done handshake between it
// and the sequencer. With n-1 = 2^r * d and d odd, a round needs one product for the
// witness, up to 2 * (log2(n) - r) - 1 for the power and up to r - 1 squarings.
// The block takes one candidate at a time; req_stall is high while it works.
// The verdict waits in an output register, so a stalled receiver does not stop the
// next candidate from being tested; only the finish of that next one waits.
// Synchronous reset clears the handshake state, sets the round count to 8 and
// loads 1 into the LFSR.

module miller_rabin_primality_test
   import mrpt_pkg::*;
#(
   parameter int NUM_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_candidate,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_probable_prime,
   output logic [ROUNDS_WIDTH-1:0]    rsp_rounds_done,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [ROUNDS_WIDTH-1:0] rounds_ff, rounds_in;
   logic [RAND_WIDTH-1:0]   lfsr_ff, lfsr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_prime_ff, rsp_prime_in;
   logic [ROUNDS_WIDTH-1:0] rsp_rounds_ff, rsp_rounds_in;

   logic [ROUNDS_WIDTH-1:0] round_limit;
   logic                    busy;
   logic                    rand_step;
   logic                    mul_start;
   logic [RAND_WIDTH-1:0]   mul_x;
   logic [NUM_WIDTH-1:0]    mul_y;
   logic [NUM_WIDTH-1:0]    mul_m;
   logic                    mul_done;
   logic [NUM_WIDTH-1:0]    mul_product;
   verdict_type             verdict;
   logic                    verdict_ready;

   assign round_limit = (int'(rounds_ff) > MAX_ROUNDS) ? ROUNDS_WIDTH'(MAX_ROUNDS) : rounds_ff;
   assign verdict_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rounds_in = rounds_ff;
      lfsr_in   = lfsr_ff;
      if (csr_wen && csr_index == CSR_ROUNDS) begin
         rounds_in = csr_wdata[ROUNDS_WIDTH-1:0];
      end
      if (csr_wen && csr_index == CSR_SEED) begin
         lfsr_in = (csr_wdata == '0) ? SEED_RESET : csr_wdata;
      end else if (rand_step) begin
         lfsr_in = lfsr_next(lfsr_ff);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_prime_in  = rsp_prime_ff;
      rsp_rounds_in = rsp_rounds_ff;
      if (verdict.valid && verdict_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_prime_in  = verdict.prime;
         rsp_rounds_in = verdict.rounds;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff    <= ROUNDS_RESET;
         lfsr_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rounds_ff    <= rounds_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_prime_ff  <= rsp_prime_in;
      rsp_rounds_ff <= rsp_rounds_in;
   end

   mrpt_seq #(
      .NUM_WIDTH(NUM_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_n        (req_candidate[NUM_WIDTH-1:0]),
      .busy         (busy),
      .round_limit  (round_limit),
      .rand_state   (lfsr_ff),
      .rand_step    (rand_step),
      .mul_start    (mul_start),
      .mul_x        (mul_x),
      .mul_y        (mul_y),
      .mul_m        (mul_m),
      .mul_done     (mul_done),
      .mul_product  (mul_product),
      .verdict      (verdict),
      .verdict_ready(verdict_ready)
   );

   mrpt_modmul #(
      .NUM_WIDTH(NUM_WIDTH)
   ) u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .x      (mul_x),
      .y      (mul_y),
      .m      (mul_m),
      .done   (mul_done),
      .product(mul_product)
   );

   assign req_stall          = busy;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probable_prime = rsp_prime_ff;
   assign rsp_rounds_done    = rsp_rounds_ff;

endmodule

[design/mrpt_modmul.sv]
// Iterative modular multiplier: (x * y) mod m, one bit of x per cycle, MSB first.
// Depends on mrpt_pkg; requires y < m and m nonzero.
`timescale 1ns / 1ps

module mrpt_modmul
   import mrpt_pkg::*;
#(
   parameter int NUM_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RAND_WIDTH-1:0] x,
   input  logic [NUM_WIDTH-1:0]  y,
   input  logic [NUM_WIDTH-1:0]  m,
   output logic                  done,
   output logic [NUM_WIDTH-1:0]  product
);

   localparam int CW = $clog2(RAND_WIDTH);
   localparam int SW = NUM_WIDTH + 2;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [RAND_WIDTH-1:0] x_ff, x_in;
   logic [NUM_WIDTH-1:0]  y_ff, y_in;
   logic [NUM_WIDTH-1:0]  m_ff, m_in;
   logic [NUM_WIDTH-1:0]  acc_ff, acc_in;

   logic [SW-1:0] sum;
   logic [SW-1:0] once_m;
   logic [SW-1:0] twice_m;
   logic [SW-1:0] reduced;

   always_comb begin
      once_m  = {2'b00, m_ff};
      twice_m = {1'b0, m_ff, 1'b0};
      sum     = {1'b0, acc_ff, 1'b0} + (x_ff[RAND_WIDTH-1] ? {2'b00, y_ff} : '0);
      priority if (sum >= twice_m) begin
         reduced = sum - twice_m;
      end else if (sum >= once_m) begin
         reduced = sum - once_m;
      end else begin
         reduced = sum;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = x;
         y_in    = y;
         m_in    = m;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = reduced[NUM_WIDTH-1:0];
         x_in   = x_ff << 1;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(RAND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[design/mrpt_seq.sv]
// Sequencer of the primality tester: splits n-1, runs witness rounds and drives
// the shared modular multiplier. Depends on mrpt_pkg.
`timescale 1ns / 1ps

module mrpt_seq
   import mrpt_pkg::*;
#(
   parameter int NUM_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [NUM_WIDTH-1:0]    req_n,
   output logic                    busy,
   input  logic [ROUNDS_WIDTH-1:0] round_limit,
   input  logic [RAND_WIDTH-1:0]   rand_state,
   output logic                    rand_step,
   output logic                    mul_start,
   output logic [RAND_WIDTH-1:0]   mul_x,
   output logic [NUM_WIDTH-1:0]    mul_y,
   output logic [NUM_WIDTH-1:0]    mul_m,
   input  logic                    mul_done,
   input  logic [NUM_WIDTH-1:0]    mul_product,
   output verdict_type             verdict,
   input  logic                    verdict_ready
);

   localparam int RW = $clog2(NUM_WIDTH);
   localparam logic [NUM_WIDTH-1:0] ONE   = NUM_WIDTH'(1);
   localparam logic [NUM_WIDTH-1:0] TWO   = NUM_WIDTH'(2);
   localparam logic [NUM_WIDTH-1:0] THREE = NUM_WIDTH'(3);
   localparam logic [NUM_WIDTH-1:0] FOUR  = NUM_WIDTH'(4);

   seq_state_type           state_ff, state_in;
   logic [NUM_WIDTH-1:0]    n_ff, n_in;
   logic [NUM_WIDTH-1:0]    d_ff, d_in;
   logic [RW-1:0]           r_ff, r_in;
   logic [RW-1:0]           j_ff, j_in;
   logic [ROUNDS_WIDTH-1:0] done_ff, done_in;
   logic [NUM_WIDTH-1:0]    acc_ff, acc_in;
   logic [NUM_WIDTH-1:0]    b_ff, b_in;
   logic [NUM_WIDTH-1:0]    e_ff, e_in;
   logic                    prime_ff, prime_in;
   logic [NUM_WIDTH-1:0]    n_minus_one;

   assign n_minus_one = n_ff - ONE;

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      r_in      = r_ff;
      j_in      = j_ff;
      done_in   = done_ff;
      acc_in    = acc_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      prime_in  = prime_ff;
      rand_step = 1'b0;
      mul_start = 1'b0;
      mul_x     = RAND_WIDTH'(acc_ff);
      mul_y     = b_ff;
      mul_m     = n_ff;
      verdict   = '{valid: 1'b0, prime: prime_ff, rounds: done_ff};

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               n_in    = req_n;
               d_in    = req_n - ONE;
               r_in    = '0;
               done_in = '0;
               priority if (req_n <= ONE) begin
                  prime_in = 1'b0;
                  state_in = SEQ_FINISH;
               end else if (req_n <= THREE) begin
                  prime_in = 1'b1;
                  state_in = SEQ_FINISH;
               end else if (!req_n[0]) begin
                  prime_in = 1'b0;
                  state_in = SEQ_FINISH;
               end else if (round_limit == '0) begin
                  prime_in = 1'b1;
                  state_in = SEQ_FINISH;
               end else begin
                  state_in = SEQ_SPLIT;
               end
            end
         end
         SEQ_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               r_in = r_ff + RW'(1);
            end else begin
               state_in = SEQ_ROUND;
            end
         end
         SEQ_ROUND: begin
            rand_step = 1'b1;
            done_in   = done_ff + ROUNDS_WIDTH'(1);
            mul_start = 1'b1;
            mul_x     = lfsr_next(rand_state);
            mul_y     = ONE;
            mul_m     = n_ff - FOUR;
            state_in  = SEQ_WITNESS;
         end
         SEQ_WITNESS: begin
            mul_m = n_ff - FOUR;
            if (mul_done) begin
               b_in     = mul_product + TWO;
               acc_in   = ONE;
               e_in     = d_ff;
               state_in = SEQ_POW;
            end
         end
         SEQ_POW: begin
            priority if (e_ff == '0) begin
               state_in = SEQ_CHECK;
            end else if (e_ff[0]) begin
               mul_start = 1'b1;
               state_in  = SEQ_POW_ACC;
            end else begin
               mul_start = 1'b1;
               mul_x     = RAND_WIDTH'(b_ff);
               e_in      = e_ff >> 1;
               state_in  = SEQ_POW_SQR;
            end
         end
         SEQ_POW_ACC: begin
            if (mul_done) begin
               acc_in   = mul_product;
               e_in     = {e_ff[NUM_WIDTH-1:1], 1'b0};
               state_in = SEQ_POW;
            end
         end
         SEQ_POW_SQR: begin
            if (mul_done) begin
               b_in     = mul_product;
               state_in = SEQ_POW;
            end
         end
         SEQ_CHECK: begin
            if (acc_ff == ONE || acc_ff == n_minus_one) begin
               state_in = SEQ_NEXT;
            end else begin
               j_in     = RW'(1);
               state_in = SEQ_SQ;
            end
         end
         SEQ_SQ: begin
            if (j_ff < r_ff) begin
               mul_start = 1'b1;
               mul_y     = acc_ff;
               state_in  = SEQ_SQ_WAIT;
            end else begin
               prime_in = 1'b0;
               state_in = SEQ_FINISH;
            end
         end
         SEQ_SQ_WAIT: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (mul_product == n_minus_one) begin
                  state_in = SEQ_NEXT;
               end else begin
                  j_in     = j_ff + RW'(1);
                  state_in = SEQ_SQ;
               end
            end
         end
         SEQ_NEXT: begin
            if (done_ff >= round_limit) begin
               prime_in = 1'b1;
               state_in = SEQ_FINISH;
            end else begin
               state_in = SEQ_ROUND;
            end
         end
         SEQ_FINISH: begin
            verdict.valid = 1'b1;
            if (verdict_ready) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff     <= n_in;
      d_ff     <= d_in;
      r_ff     <= r_in;
      j_ff     <= j_in;
      done_ff  <= done_in;
      acc_ff   <= acc_in;
      b_ff     <= b_in;
      e_ff     <= e_in;
      prime_ff <= prime_in;
   end

   assign busy = (state_ff != SEQ_IDLE);

endmodule

[tb/miller_rabin_primality_test_tb.sv]
// Self-checking testbench for the Miller-Rabin primality tester: it drives candidates,
// predicts each verdict with its own square-and-multiply model and checks every transfer.
// Depends on mrpt_pkg and the miller_rabin_primality_test design.
`timescale 1ns / 1ps

module miller_rabin_primality_test_tb;
   import mrpt_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_3 = 2'd3;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 20;

   typedef struct packed {
      logic                    prime;
      logic [ROUNDS_WIDTH-1:0] rounds;
   } exp_verdict_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [31:0]                req_candidate = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_probable_prime;
   logic [ROUNDS_WIDTH-1:0]    rsp_rounds_done;
   logic                       csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   logic [ROUNDS_WIDTH-1:0] rounds_setting = ROUNDS_RESET;
   logic [RAND_WIDTH-1:0]   witness_gen = SEED_RESET;

   logic [31:0]     candidates_pending[$];
   exp_verdict_type verdicts_due[$];
   exp_verdict_type want;
   int              fail_count = 0;

   logic        req_fire = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;

   logic           hold_start = 1'b0;
   logic           hold_taken = 1'b0;
   int             hold_left = 0;
   logic [31:0]    stall_tick = '0;
   stall_mode_type stall_mode = STALL_NONE;

   logic [31:0] directed_candidates[19] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9, 32'd25,
      32'd561, 32'd2047, 32'd65537, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
      32'h7FFF_FFFF, 32'hFFFF_FFFB, 32'd3221225473
   };
   logic [31:0] prime_pool[12] = '{
      32'd5, 32'd7, 32'd11, 32'd13, 32'd17, 32'd97, 32'd257, 32'd4093, 32'd65521,
      32'd65537, 32'd2147483647, 32'd4294967291
   };
   logic [31:0] liar_pool[12] = '{
      32'd561, 32'd1105, 32'd1729, 32'd2047, 32'd2465, 32'd3277, 32'd4033,
      32'd4681, 32'd8321, 32'd1373653, 32'd25326001, 32'd3215031751
   };

   miller_rabin_primality_test u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_candidate      (req_candidate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_probable_prime (rsp_probable_prime),
      .rsp_rounds_done    (rsp_rounds_done),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [RAND_WIDTH-1:0] gen_advance(input logic [RAND_WIDTH-1:0] s);
      return {1'b0, s[RAND_WIDTH-1:1]} ^ (s[0] ? LFSR_TAPS : '0);
   endfunction

   function automatic logic [63:0] mod_exp(input logic [63:0] base, input logic [63:0] expo,
                                           input logic [63:0] n);
      logic [63:0] acc, b, e;
      acc = 64'd1 % n;
      b = base % n;
      e = expo;
      while (e != 0) begin
         if (e[0]) begin
            acc = (acc * b) % n;
         end
         e = e >> 1;
         b = (b * b) % n;
      end
      return acc;
   endfunction

   // Advances the witness generator exactly as the block does for one candidate.
   function automatic exp_verdict_type primality_verdict(input logic [31:0] cand);
      logic [63:0]     n, d, a, x;
      int              r, j, limit, done;
      logic            hit, dead;
      exp_verdict_type v;
      n = {32'd0, cand};
      limit = (rounds_setting > MAX_ROUNDS) ? MAX_ROUNDS : rounds_setting;
      done = 0;
      dead = 1'b0;
      if (n <= 1) begin
         dead = 1'b1;
      end else if (n <= 3) begin
         dead = 1'b0;
      end else if (!n[0]) begin
         dead = 1'b1;
      end else begin
         d = n - 1;
         r = 0;
         while (!d[0]) begin
            d = d >> 1;
            r++;
         end
         while (done < limit && !dead) begin
            witness_gen = gen_advance(witness_gen);
            done++;
            a = 64'd2 + ({32'd0, witness_gen} % (n - 4));
            x = mod_exp(a, d, n);
            if (x != 1 && x != n - 1) begin
               hit = 1'b0;
               j = 1;
               while (j < r && !hit) begin
                  x = (x * x) % n;
                  if (x == n - 1) begin
                     hit = 1'b1;
                  end
                  j++;
               end
               dead = !hit;
            end
         end
      end
      v.prime = !dead;
      v.rounds = done[ROUNDS_WIDTH-1:0];
      return v;
   endfunction

   function automatic logic [31:0] pick_candidate();
      case ($urandom_range(0, 19))
         0, 1, 2: return $urandom;
         3:       return $urandom_range(0, 4);
         4, 5, 6: return prime_pool[$urandom_range(0, 11)];
         7, 8:    return liar_pool[$urandom_range(0, 11)];
         default: return $urandom_range(5, 4095) | 32'd1;
      endcase
   endfunction

   // Candidate driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (req_valid && !req_fire) begin
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (candidates_pending.size() != 0) begin
         req_valid <= 1'b1;
         req_candidate <= candidates_pending.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Verdict receiver: changes its stall pattern whenever the low byte of its tick counter wraps, with one long hold.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick[7:0] == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
         end
         if (hold_start && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= stall_tick[3];
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected verdict prime=%0b rounds=%0d", $time,
                        rsp_probable_prime, rsp_rounds_done);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_probable_prime !== want.prime || rsp_rounds_done !== want.rounds) begin
                  $display(
                     "%0t: mismatch: expected prime=%0b rounds=%0d, got prime=%0b rounds=%0d",
                     $time, want.prime, want.rounds, rsp_probable_prime, rsp_rounds_done);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            verdicts_due.push_back(primality_verdict(req_candidate));
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx == CSR_ROUNDS) begin
         rounds_setting = data[ROUNDS_WIDTH-1:0];
      end else if (idx == CSR_SEED) begin
         witness_gen = (data == 0) ? 32'd1 : data;
      end
   endtask

   task automatic drain();
      while (candidates_pending.size() != 0 || verdicts_due.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [31:0] wide;
      int          k, ph;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      foreach (directed_candidates[di]) begin
         candidates_pending.push_back(directed_candidates[di]);
      end
      drain();

      // No rounds: odd candidates pass at once. The receiver holds off meanwhile.
      write_reg(CSR_ROUNDS, 32'hFFFF_FF80);
      write_reg(CSR_SPARE_2, 32'd7);
      write_reg(CSR_SPARE_3, 32'd0);
      @(posedge clock);
      hold_start = 1'b1;
      for (k = 0; k < 20; k++) begin
         candidates_pending.push_back((k % 4 == 3) ? ($urandom & ~32'd1) : ($urandom | 32'd1));
      end
      candidates_pending.push_back(32'd5);
      drain();

      write_reg(CSR_ROUNDS, 32'd127);
      write_reg(CSR_SEED, 32'd0);
      @(posedge clock);
      candidates_pending.push_back(32'd5);
      candidates_pending.push_back(32'd101);
      drain();

      write_reg(CSR_ROUNDS, MAX_ROUNDS);
      @(posedge clock);
      candidates_pending.push_back(32'd13);
      candidates_pending.push_back(32'd7);
      drain();

      write_reg(CSR_ROUNDS, 32'd1);
      write_reg(CSR_SEED, 32'hFFFF_FFFF);
      @(posedge clock);
      for (k = 0; k < 20; k++) begin
         candidates_pending.push_back(pick_candidate());
      end
      drain();

      for (ph = 0; ph < 4; ph++) begin
         wide = $urandom;
         wide[ROUNDS_WIDTH-1:0] = $urandom_range(1, 6);
         write_reg(CSR_ROUNDS, wide);
         write_reg(CSR_SEED, $urandom);
         @(posedge clock);
         for (k = 0; k < 10; k++) begin
            candidates_pending.push_back(pick_candidate());
         end
         drain();
      end

      if (fail_count == 0 && verdicts_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
design/mrpt_pkg.sv
design/mrpt_modmul.sv
design/mrpt_seq.sv
design/miller_rabin_primality_test.sv
tb/miller_rabin_primality_test_tb.sv
